// ----- rtl/conv3_pkg.sv -----
`timescale 1ns / 1ps

package conv3_pkg;

  localparam int PIX_W          = 8;
  localparam int COEF_W         = 16;
  localparam int TAPS           = 9;
  localparam int TAP_IDX_W      = $clog2(TAPS);
  // Largest magnitude is 9 * 32768 * 255, which needs 27 bits plus sign.
  localparam int SUM_W          = 28;
  localparam int DIV_W          = 16;
  localparam int DIV_CNT_W      = $clog2(SUM_W);
  localparam int OUT_W          = 16;
  localparam int MAX_LINE_WIDTH = 2048;
  localparam int LINE_ADDR_W    = $clog2(MAX_LINE_WIDTH);
  localparam int COL_W          = 12;
  localparam int ROW_W          = 12;
  localparam int HGT_W          = 13;
  localparam int MAX_FRAME_HGT  = 4096;
  localparam int CFG_W          = 48;
  localparam int CFG_IDX_W      = 3;

  typedef logic [TAPS-1:0][PIX_W-1:0]  win_pix_t;
  typedef logic [TAPS-1:0][COEF_W-1:0] win_coef_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] quot;
    logic                    sat;
  } div_res_t;

endpackage

// ----- rtl/conv3_ram.sv -----
`timescale 1ns / 1ps

module conv3_ram #(
  parameter int DEPTH  = 2048,
  parameter int WIDTH  = 8,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/conv3_mac.sv -----
`timescale 1ns / 1ps

module conv3_mac (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  conv3_pkg::win_pix_t               pix,
  input  conv3_pkg::win_coef_t              coef,
  output logic                              done,
  output logic signed [conv3_pkg::SUM_W-1:0] sum
);

  logic                                      busy_r, busy_nxt;
  logic                                      done_r, done_nxt;
  logic [conv3_pkg::TAP_IDX_W-1:0]           k_r, k_nxt;
  logic signed [conv3_pkg::SUM_W-1:0]        acc_r, acc_nxt;
  logic [conv3_pkg::PIX_W-1:0]               pix_sel;
  logic [conv3_pkg::COEF_W-1:0]              coef_sel;
  logic signed [conv3_pkg::COEF_W+conv3_pkg::PIX_W:0] prod;

  assign pix_sel  = pix[k_r];
  assign coef_sel = coef[k_r];
  assign prod     = $signed(coef_sel) * $signed({1'b0, pix_sel});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    k_nxt    = k_r;
    acc_nxt  = acc_r;
    if (start) begin
      busy_nxt = 1'b1;
      k_nxt    = '0;
      acc_nxt  = '0;
    end else if (busy_r) begin
      acc_nxt = acc_r + conv3_pkg::SUM_W'(prod);
      k_nxt   = k_r + 1'b1;
      if (k_r == conv3_pkg::TAP_IDX_W'(conv3_pkg::TAPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    k_r   <= k_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign sum  = acc_r;

endmodule

// ----- rtl/conv3_div.sv -----
`timescale 1ns / 1ps

module conv3_div (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic signed [conv3_pkg::SUM_W-1:0] dividend,
  input  logic [conv3_pkg::DIV_W-1:0]        divisor,
  output logic                               done,
  output conv3_pkg::div_res_t                res
);

  logic                               busy_r, busy_nxt;
  logic                               done_r, done_nxt;
  logic [conv3_pkg::DIV_CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [conv3_pkg::SUM_W-1:0]        q_r, q_nxt;
  logic [conv3_pkg::DIV_W-1:0]        rem_r, rem_nxt;
  logic                               neg_r, neg_nxt;
  logic [conv3_pkg::DIV_W:0]          trial;
  logic [conv3_pkg::DIV_W:0]          diff;
  logic                               pos_sat;
  logic                               neg_sat;

  assign trial = {rem_r, q_r[conv3_pkg::SUM_W-1]};
  assign diff  = trial - {1'b0, divisor};

  // Restoring division on the magnitude, one quotient bit per cycle.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    neg_nxt  = neg_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      neg_nxt  = dividend[conv3_pkg::SUM_W-1];
      q_nxt    = dividend[conv3_pkg::SUM_W-1] ? conv3_pkg::SUM_W'(-dividend)
                                               : conv3_pkg::SUM_W'(dividend);
    end else if (busy_r) begin
      if (!diff[conv3_pkg::DIV_W]) begin
        rem_nxt = diff[conv3_pkg::DIV_W-1:0];
        q_nxt   = {q_r[conv3_pkg::SUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[conv3_pkg::DIV_W-1:0];
        q_nxt   = {q_r[conv3_pkg::SUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == conv3_pkg::DIV_CNT_W'(conv3_pkg::SUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    neg_r <= neg_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // Positive side clips above 32767, negative side below -32768.
  assign pos_sat = |q_r[conv3_pkg::SUM_W-1:conv3_pkg::OUT_W-1];
  assign neg_sat = (|q_r[conv3_pkg::SUM_W-1:conv3_pkg::OUT_W]) ||
                   (q_r[conv3_pkg::OUT_W-1] && (|q_r[conv3_pkg::OUT_W-2:0]));

  always_comb begin
    if (neg_r) begin
      res.sat  = neg_sat;
      res.quot = neg_sat ? {1'b1, {(conv3_pkg::OUT_W-1){1'b0}}}
                         : -$signed(q_r[conv3_pkg::OUT_W-1:0]);
    end else begin
      res.sat  = pos_sat;
      res.quot = pos_sat ? {1'b0, {(conv3_pkg::OUT_W-1){1'b1}}}
                         : $signed(q_r[conv3_pkg::OUT_W-1:0]);
    end
  end

  assign done = done_r;

endmodule

// ----- rtl/conv3x3_integer_kernel.sv -----
`timescale 1ns / 1ps
// Channel   Handshake              Payload
// in        in_valid / in_ready    in_pixel[7:0], in_frame_start
// out       out_valid / out_ready  out_filtered[15:0] signed, out_saturated, out_frame_last
// cfg       cfg_we                 cfg_idx[2:0], cfg_wdata[47:0]
//
// A pixel that completes no window passes through the transaction and one line-store read.
// A pixel that completes a window passes through the line-store read, a nine-step
// multiply-accumulate on one multiplier, and a 28-step radix-2 divider.
// Reset is synchronous and active low; the line stores are not cleared.
// A result waiting on out_ready does not block the next input transaction; only
// the following result waits until the output register is free.

module conv3x3_integer_kernel (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [conv3_pkg::PIX_W-1:0]           in_pixel,
  input  logic                                  in_frame_start,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [conv3_pkg::OUT_W-1:0]    out_filtered,
  output logic                                  out_saturated,
  output logic                                  out_frame_last,
  input  logic                                  cfg_we,
  input  logic [conv3_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [conv3_pkg::CFG_W-1:0]           cfg_wdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_MAC,
    S_DIV,
    S_OUT
  } state_t;

  typedef enum logic [conv3_pkg::CFG_IDX_W-1:0] {
    CFG_COEF_TOP     = 3'd0,
    CFG_COEF_MID     = 3'd1,
    CFG_COEF_BOT     = 3'd2,
    CFG_DIVISOR      = 3'd3,
    CFG_LINE_WIDTH   = 3'd4,
    CFG_FRAME_HEIGHT = 3'd5
  } cfg_idx_t;

  localparam int MIN_DIM = 3;
  localparam int WIN_EDGE = 2;
  localparam logic [conv3_pkg::CFG_W-1:0] RST_COEF_MID = conv3_pkg::CFG_W'(65536);
  localparam logic [conv3_pkg::COL_W-1:0] RST_WIDTH    = conv3_pkg::COL_W'(640);
  localparam logic [conv3_pkg::HGT_W-1:0] RST_HEIGHT   = conv3_pkg::HGT_W'(480);

  state_t                              state_r, state_nxt;
  logic [conv3_pkg::CFG_W-1:0]         coef_top_r, coef_top_nxt;
  logic [conv3_pkg::CFG_W-1:0]         coef_mid_r, coef_mid_nxt;
  logic [conv3_pkg::CFG_W-1:0]         coef_bot_r, coef_bot_nxt;
  logic [conv3_pkg::DIV_W-1:0]         divisor_r, divisor_nxt;
  logic [conv3_pkg::COL_W-1:0]         width_r, width_nxt;
  logic [conv3_pkg::HGT_W-1:0]         height_r, height_nxt;
  logic [conv3_pkg::COL_W-1:0]         col_cnt_r, col_cnt_nxt;
  logic [conv3_pkg::ROW_W-1:0]         row_cnt_r, row_cnt_nxt;
  logic [conv3_pkg::COL_W-1:0]         col_r, col_nxt;
  logic [conv3_pkg::ROW_W-1:0]         row_r, row_nxt;
  logic [conv3_pkg::PIX_W-1:0]         px_r, px_nxt;
  logic [5:0][conv3_pkg::PIX_W-1:0]    wc_r, wc_nxt;
  conv3_pkg::win_pix_t                 win_r, win_nxt;
  logic                                last_r, last_nxt;
  logic                                out_valid_r, out_valid_nxt;
  logic signed [conv3_pkg::OUT_W-1:0]  out_filtered_r, out_filtered_nxt;
  logic                                out_sat_r, out_sat_nxt;
  logic                                out_last_r, out_last_nxt;

  logic                                in_accept;
  logic [conv3_pkg::COL_W-1:0]         c0, c1, cn;
  logic [conv3_pkg::HGT_W-1:0]         r0, r1, r2, rn;
  logic [conv3_pkg::PIX_W-1:0]         up_q, lo_q;
  logic [2:0][conv3_pkg::PIX_W-1:0]    right_col;
  logic                                emit;
  logic                                ls_we;
  logic [conv3_pkg::COL_W-1:0]         width_in;
  logic [conv3_pkg::HGT_W-1:0]         height_in;
  conv3_pkg::win_coef_t                coefs;
  logic                                mac_start, mac_done;
  logic signed [conv3_pkg::SUM_W-1:0]  mac_sum;
  logic                                div_start, div_done;
  conv3_pkg::div_res_t                 div_res;

  assign in_ready  = (state_r == S_IDLE);
  assign in_accept = in_valid && in_ready;

  // Position of the incoming pixel, after frame start and any geometry change.
  always_comb begin
    c0 = in_frame_start ? '0 : col_cnt_r;
    r0 = in_frame_start ? '0 : {1'b0, row_cnt_r};
    c1 = c0;
    r1 = r0;
    if (c0 >= width_r) begin
      c1 = '0;
      r1 = r0 + 1'b1;
    end
    r2 = (r1 >= height_r) ? '0 : r1;
  end

  assign ls_we = (state_r == S_READ);

  conv3_ram #(
    .DEPTH (conv3_pkg::MAX_LINE_WIDTH),
    .WIDTH (conv3_pkg::PIX_W)
  ) u_upper (
    .clk   (clk),
    .we    (ls_we),
    .waddr (col_r[conv3_pkg::LINE_ADDR_W-1:0]),
    .wdata (lo_q),
    .re    (in_accept),
    .raddr (c1[conv3_pkg::LINE_ADDR_W-1:0]),
    .rdata (up_q)
  );

  conv3_ram #(
    .DEPTH (conv3_pkg::MAX_LINE_WIDTH),
    .WIDTH (conv3_pkg::PIX_W)
  ) u_lower (
    .clk   (clk),
    .we    (ls_we),
    .waddr (col_r[conv3_pkg::LINE_ADDR_W-1:0]),
    .wdata (px_r),
    .re    (in_accept),
    .raddr (c1[conv3_pkg::LINE_ADDR_W-1:0]),
    .rdata (lo_q)
  );

  assign right_col[0] = up_q;
  assign right_col[1] = lo_q;
  assign right_col[2] = px_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      coefs[i*3 + 1] = (i == 0) ? coef_top_r[16 +: conv3_pkg::COEF_W] :
                       (i == 1) ? coef_mid_r[16 +: conv3_pkg::COEF_W] :
                                  coef_bot_r[16 +: conv3_pkg::COEF_W];
      coefs[i*3 + 2] = (i == 0) ? coef_top_r[32 +: conv3_pkg::COEF_W] :
                       (i == 1) ? coef_mid_r[32 +: conv3_pkg::COEF_W] :
                                  coef_bot_r[32 +: conv3_pkg::COEF_W];
      coefs[i*3]     = (i == 0) ? coef_top_r[0 +: conv3_pkg::COEF_W] :
                       (i == 1) ? coef_mid_r[0 +: conv3_pkg::COEF_W] :
                                  coef_bot_r[0 +: conv3_pkg::COEF_W];
    end
  end

  // Clamp geometry at write time; only the clamped values are ever used.
  always_comb begin
    width_in = cfg_wdata[conv3_pkg::COL_W-1:0];
    if (width_in < conv3_pkg::COL_W'(MIN_DIM)) begin
      width_in = conv3_pkg::COL_W'(MIN_DIM);
    end else if (width_in > conv3_pkg::COL_W'(conv3_pkg::MAX_LINE_WIDTH)) begin
      width_in = conv3_pkg::COL_W'(conv3_pkg::MAX_LINE_WIDTH);
    end
    height_in = cfg_wdata[conv3_pkg::HGT_W-1:0];
    if (height_in < conv3_pkg::HGT_W'(MIN_DIM)) begin
      height_in = conv3_pkg::HGT_W'(MIN_DIM);
    end else if (height_in > conv3_pkg::HGT_W'(conv3_pkg::MAX_FRAME_HGT)) begin
      height_in = conv3_pkg::HGT_W'(conv3_pkg::MAX_FRAME_HGT);
    end
  end

  always_comb begin
    coef_top_nxt = coef_top_r;
    coef_mid_nxt = coef_mid_r;
    coef_bot_nxt = coef_bot_r;
    divisor_nxt  = divisor_r;
    width_nxt    = width_r;
    height_nxt   = height_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_idx))
        CFG_COEF_TOP:     coef_top_nxt = cfg_wdata;
        CFG_COEF_MID:     coef_mid_nxt = cfg_wdata;
        CFG_COEF_BOT:     coef_bot_nxt = cfg_wdata;
        CFG_DIVISOR: begin
          divisor_nxt = (cfg_wdata[conv3_pkg::DIV_W-1:0] == '0) ?
                        conv3_pkg::DIV_W'(1) : cfg_wdata[conv3_pkg::DIV_W-1:0];
        end
        CFG_LINE_WIDTH:   width_nxt  = width_in;
        CFG_FRAME_HEIGHT: height_nxt = height_in;
        default: ;
      endcase
    end
  end

  assign emit = (col_r >= conv3_pkg::COL_W'(WIN_EDGE)) &&
                (row_r >= conv3_pkg::ROW_W'(WIN_EDGE));
  assign cn   = col_r + 1'b1;
  assign rn   = {1'b0, row_r} + 1'b1;

  always_comb begin
    state_nxt        = state_r;
    col_cnt_nxt      = col_cnt_r;
    row_cnt_nxt      = row_cnt_r;
    col_nxt          = col_r;
    row_nxt          = row_r;
    px_nxt           = px_r;
    wc_nxt           = wc_r;
    win_nxt          = win_r;
    last_nxt         = last_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    out_filtered_nxt = out_filtered_r;
    out_sat_nxt      = out_sat_r;
    out_last_nxt     = out_last_r;
    mac_start        = 1'b0;
    div_start        = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          col_nxt   = c1;
          row_nxt   = r2[conv3_pkg::ROW_W-1:0];
          px_nxt    = in_pixel;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        // Window taps run top-left to bottom-right, matching the coefficient order.
        for (int i = 0; i < 3; i++) begin
          win_nxt[i*3]     = wc_r[i];
          win_nxt[i*3 + 1] = wc_r[3 + i];
          win_nxt[i*3 + 2] = right_col[i];
          wc_nxt[i]        = wc_r[3 + i];
          wc_nxt[3 + i]    = right_col[i];
        end
        last_nxt = ({1'b0, row_r} == height_r - 1'b1) && (col_r == width_r - 1'b1);
        if (cn >= width_r) begin
          col_cnt_nxt = '0;
          row_cnt_nxt = (rn >= height_r) ? '0 : rn[conv3_pkg::ROW_W-1:0];
        end else begin
          col_cnt_nxt = cn;
          row_cnt_nxt = row_r;
        end
        if (emit) begin
          mac_start = 1'b1;
          state_nxt = S_MAC;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_MAC: begin
        if (mac_done) begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt    = 1'b1;
          out_filtered_nxt = div_res.quot;
          out_sat_nxt      = div_res.sat;
          out_last_nxt     = last_r;
          state_nxt        = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    col_r          <= col_nxt;
    row_r          <= row_nxt;
    px_r           <= px_nxt;
    win_r          <= win_nxt;
    last_r         <= last_nxt;
    out_filtered_r <= out_filtered_nxt;
    out_sat_r      <= out_sat_nxt;
    out_last_r     <= out_last_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      coef_top_r  <= '0;
      coef_mid_r  <= RST_COEF_MID;
      coef_bot_r  <= '0;
      divisor_r   <= conv3_pkg::DIV_W'(1);
      width_r     <= RST_WIDTH;
      height_r    <= RST_HEIGHT;
      col_cnt_r   <= '0;
      row_cnt_r   <= '0;
      wc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      coef_top_r  <= coef_top_nxt;
      coef_mid_r  <= coef_mid_nxt;
      coef_bot_r  <= coef_bot_nxt;
      divisor_r   <= divisor_nxt;
      width_r     <= width_nxt;
      height_r    <= height_nxt;
      col_cnt_r   <= col_cnt_nxt;
      row_cnt_r   <= row_cnt_nxt;
      wc_r        <= wc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  conv3_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mac_start),
    .pix   (win_r),
    .coef  (coefs),
    .done  (mac_done),
    .sum   (mac_sum)
  );

  conv3_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mac_sum),
    .divisor  (divisor_r),
    .done     (div_done),
    .res      (div_res)
  );

  assign out_valid      = out_valid_r;
  assign out_filtered   = out_filtered_r;
  assign out_saturated  = out_sat_r;
  assign out_frame_last = out_last_r;

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;

  localparam logic [conv3_pkg::CFG_IDX_W-1:0] REG_COEF_TOP    = conv3_pkg::CFG_IDX_W'(0);
  localparam logic [conv3_pkg::CFG_IDX_W-1:0] REG_COEF_MIDDLE = conv3_pkg::CFG_IDX_W'(1);
  localparam logic [conv3_pkg::CFG_IDX_W-1:0] REG_COEF_BOTTOM = conv3_pkg::CFG_IDX_W'(2);
  localparam logic [conv3_pkg::CFG_IDX_W-1:0] REG_DIVISOR     = conv3_pkg::CFG_IDX_W'(3);
  localparam logic [conv3_pkg::CFG_IDX_W-1:0] REG_LINE_WIDTH  = conv3_pkg::CFG_IDX_W'(4);
  localparam logic [conv3_pkg::CFG_IDX_W-1:0] REG_FRAME_HGT   = conv3_pkg::CFG_IDX_W'(5);

  localparam int RANDOM_PIXELS   = 1550;
  localparam int OVERSIZE_PIXELS = 40;
  localparam int SETTLE_CYCLES   = 64;
  localparam int WATCHDOG_LIMIT  = 2000;

  typedef struct packed {
    logic signed [conv3_pkg::OUT_W-1:0] filtered;
    logic                               saturated;
    logic                               frame_last;
  } filter_result_t;

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               in_valid = 1'b0;
  logic                               in_ready;
  logic [conv3_pkg::PIX_W-1:0]        in_pixel = '0;
  logic                               in_frame_start = 1'b0;
  logic                               out_valid;
  logic                               out_ready = 1'b0;
  logic signed [conv3_pkg::OUT_W-1:0] out_filtered;
  logic                               out_saturated;
  logic                               out_frame_last;
  logic                               cfg_we = 1'b0;
  logic [conv3_pkg::CFG_IDX_W-1:0]    cfg_idx = '0;
  logic [conv3_pkg::CFG_W-1:0]        cfg_wdata = '0;

  conv3x3_integer_kernel i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_pixel       (in_pixel),
    .in_frame_start (in_frame_start),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_filtered   (out_filtered),
    .out_saturated  (out_saturated),
    .out_frame_last (out_frame_last),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_idx),
    .cfg_wdata      (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Mirror of the filter: registers, line stores, window and raster position.
  logic [conv3_pkg::CFG_W-1:0]  coef_row [3];
  logic [conv3_pkg::DIV_W-1:0]  div_reg;
  logic [conv3_pkg::COL_W-1:0]  width_reg;
  logic [conv3_pkg::HGT_W-1:0]  height_reg;
  logic [conv3_pkg::PIX_W-1:0]  upper_line [conv3_pkg::MAX_LINE_WIDTH];
  logic [conv3_pkg::PIX_W-1:0]  lower_line [conv3_pkg::MAX_LINE_WIDTH];
  // Store entries holding known pixels; the hardware stores are not cleared by reset.
  bit                           upper_known [conv3_pkg::MAX_LINE_WIDTH];
  bit                           lower_known [conv3_pkg::MAX_LINE_WIDTH];
  logic [conv3_pkg::PIX_W-1:0]  window_px [6];
  int unsigned                  col_pos;
  int unsigned                  row_pos;

  filter_result_t    filter_results_due [$];

  bit                gaps_on = 1'b1;
  int                error_count = 0;
  int                pixels_sent = 0;
  int                results_checked = 0;
  int                saturated_seen = 0;
  int                frame_ends_seen = 0;
  int                setups_done = 0;
  int                idle_cycles = 0;

  function automatic void reset_filter_model();
    coef_row[0] = '0;
    coef_row[1] = 48'h0000_0001_0000;
    coef_row[2] = '0;
    div_reg     = 16'd1;
    width_reg   = 12'd640;
    height_reg  = 13'd480;
    for (int c = 0; c < conv3_pkg::MAX_LINE_WIDTH; c++) begin
      upper_known[c] = 1'b0;
      lower_known[c] = 1'b0;
    end
    for (int k = 0; k < 6; k++) window_px[k] = '0;
    col_pos = 0;
    row_pos = 0;
  endfunction

  function automatic int unsigned line_len();
    int unsigned w;
    w = width_reg;
    if (w < 3) w = 3;
    if (w > conv3_pkg::MAX_LINE_WIDTH) w = conv3_pkg::MAX_LINE_WIDTH;
    return w;
  endfunction

  function automatic int unsigned frame_rows();
    int unsigned h;
    h = height_reg;
    if (h < 3) h = 3;
    if (h > conv3_pkg::MAX_FRAME_HGT) h = conv3_pkg::MAX_FRAME_HGT;
    return h;
  endfunction

  function automatic bit stores_known(input int unsigned n);
    for (int c = 0; c < n; c++)
      if (!upper_known[c] || !lower_known[c]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic bit at_frame_start();
    return col_pos == 0 && row_pos == 0;
  endfunction

  function automatic void update_register(input logic [conv3_pkg::CFG_IDX_W-1:0] idx,
                                          input logic [conv3_pkg::CFG_W-1:0] data);
    case (idx)
      REG_COEF_TOP:    coef_row[0] = data;
      REG_COEF_MIDDLE: coef_row[1] = data;
      REG_COEF_BOTTOM: coef_row[2] = data;
      REG_DIVISOR:     div_reg = data[conv3_pkg::DIV_W-1:0];
      REG_LINE_WIDTH:  width_reg = data[conv3_pkg::COL_W-1:0];
      REG_FRAME_HGT:   height_reg = data[conv3_pkg::HGT_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic int reg_bits(input logic [conv3_pkg::CFG_IDX_W-1:0] idx);
    case (idx)
      REG_DIVISOR:    return conv3_pkg::DIV_W;
      REG_LINE_WIDTH: return conv3_pkg::COL_W;
      REG_FRAME_HGT:  return conv3_pkg::HGT_W;
      default:        return conv3_pkg::CFG_W;
    endcase
  endfunction

  // Advances the raster by one pixel and queues the window result it completes.
  function automatic void convolve_pixel(input logic [conv3_pkg::PIX_W-1:0] px,
                                         input logic fs);
    int unsigned    w, h, col, row;
    logic [conv3_pkg::PIX_W-1:0] tap_px [3][3];
    longint         acc, quo, dv;
    bit             emit, sat;
    filter_result_t res;
    w = line_len();
    h = frame_rows();
    if (fs) begin
      col_pos = 0;
      row_pos = 0;
    end
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) row_pos = 0;
    col = col_pos;
    row = row_pos;
    // tap_px is indexed [column][row]; columns run left to right.
    for (int i = 0; i < 3; i++) begin
      tap_px[0][i] = window_px[i];
      tap_px[1][i] = window_px[3 + i];
    end
    tap_px[2][0] = upper_line[col];
    tap_px[2][1] = lower_line[col];
    tap_px[2][2] = px;
    emit = (col >= 2) && (row >= 2);
    acc = 0;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        acc += longint'($signed(coef_row[i][16*j +: 16])) * longint'(tap_px[j][i]);
    dv = (div_reg == '0) ? 1 : longint'(div_reg);
    quo = acc / dv;
    sat = 1'b0;
    if (quo > 32767) begin
      quo = 32767;
      sat = 1'b1;
    end
    if (quo < -32768) begin
      quo = -32768;
      sat = 1'b1;
    end
    upper_line[col]  = lower_line[col];
    upper_known[col] = lower_known[col];
    lower_line[col]  = px;
    lower_known[col] = 1'b1;
    for (int i = 0; i < 3; i++) begin
      window_px[i]     = tap_px[1][i];
      window_px[3 + i] = tap_px[2][i];
    end
    col_pos = col + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = row + 1;
      if (row_pos >= h) row_pos = 0;
    end
    if (emit) begin
      res.filtered   = quo[conv3_pkg::OUT_W-1:0];
      res.saturated  = sat;
      res.frame_last = (row == h - 1) && (col == w - 1);
      filter_results_due.push_back(res);
    end
  endfunction

  function automatic logic [conv3_pkg::PIX_W-1:0] pick_pixel();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return conv3_pkg::PIX_W'($urandom);
    endcase
  endfunction

  function automatic logic [conv3_pkg::COEF_W-1:0] pick_coef();
    case ($urandom_range(0, 5))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2, 3:    return 16'($urandom_range(0, 8)) - 16'd4;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [conv3_pkg::CFG_W-1:0] pick_coef_row();
    if ($urandom_range(0, 4) == 0) return '0;
    return {pick_coef(), pick_coef(), pick_coef()};
  endfunction

  function automatic logic [conv3_pkg::DIV_W-1:0] pick_divisor();
    case ($urandom_range(0, 6))
      0:       return '0;
      1:       return 16'd1;
      2:       return '1;
      3, 4:    return 16'($urandom_range(1, 64));
      default: return 16'($urandom);
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_pixel(input logic [conv3_pkg::PIX_W-1:0] px, input logic fs);
    int gap;
    gap = gaps_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_pixel       <= px;
    in_frame_start <= fs;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    convolve_pixel(px, fs);
    pixels_sent++;
    @(negedge clk);
  endtask

  // Bits above the register's width carry junk that the block must ignore.
  task automatic write_reg(input logic [conv3_pkg::CFG_IDX_W-1:0] idx,
                           input logic [conv3_pkg::CFG_W-1:0] value);
    logic [conv3_pkg::CFG_W-1:0] mask, junk;
    mask = '1;
    mask = mask >> (conv3_pkg::CFG_W - reg_bits(idx));
    junk = conv3_pkg::CFG_W'({$urandom, $urandom});
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= (value & mask) | (junk & ~mask);
    update_register(idx, value);
    @(negedge clk);
  endtask

  task automatic end_writes();
    cfg_we <= 1'b0;
    setups_done++;
  endtask

  task automatic apply_setup(input logic [conv3_pkg::CFG_W-1:0] top,
                             input logic [conv3_pkg::CFG_W-1:0] mid,
                             input logic [conv3_pkg::CFG_W-1:0] bot,
                             input logic [conv3_pkg::DIV_W-1:0] dv,
                             input logic [conv3_pkg::COL_W-1:0] w,
                             input logic [conv3_pkg::HGT_W-1:0] h);
    write_reg(REG_COEF_TOP, top);
    write_reg(REG_COEF_MIDDLE, mid);
    write_reg(REG_COEF_BOTTOM, bot);
    write_reg(REG_DIVISOR, dv);
    write_reg(REG_LINE_WIDTH, w);
    write_reg(REG_FRAME_HGT, h);
    end_writes();
  endtask

  // Lets the block run dry, including a pixel that makes no result.
  task automatic finish_phase();
    in_valid <= 1'b0;
    while (filter_results_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic stream_pixels(input int count, input bit start_now);
    logic fs;
    for (int k = 0; k < count; k++) begin
      fs = 1'b0;
      if (k == 0 && start_now) fs = 1'b1;
      else if (at_frame_start()) fs = ($urandom_range(0, 9) < 7);
      else if ($urandom_range(0, 49) == 0) fs = 1'b1;  // abandon the frame early
      send_pixel(pick_pixel(), fs);
    end
  endtask

  // Reset coefficients form the identity filter; register values below 3 clamp to 3.
  task automatic test_identity_small_frames();
    logic [conv3_pkg::PIX_W-1:0] px;
    write_reg(REG_LINE_WIDTH, 12'd0);
    write_reg(REG_FRAME_HGT, 13'd2);
    end_writes();
    // The second frame follows without a frame start and must wrap on its own.
    for (int k = 0; k < 18; k++) begin
      if (k % 9 == 4) px = (k < 9) ? 8'hFF : 8'h00;
      else px = (k < 9) ? pick_pixel() : 8'hFF;
      send_pixel(px, k == 0);
    end
  endtask

  // Largest positive and negative weights with divisor zero drive both saturation limits.
  task automatic test_saturation_limits();
    finish_phase();
    apply_setup({3{16'h7FFF}}, '0, {3{16'h8000}}, 16'd0, 12'd3, 13'd4);
    for (int k = 0; k < 12; k++)
      send_pixel((k / 3 == 0 || k / 3 == 3) ? 8'hFF : 8'h00, k == 0);
  endtask

  task automatic test_random_frames();
    int  target;
    bit  restart;
    logic [conv3_pkg::COL_W-1:0] w;
    logic [conv3_pkg::HGT_W-1:0] h;
    target = pixels_sent + RANDOM_PIXELS;
    while (pixels_sent < target) begin
      finish_phase();
      gaps_on = ($urandom_range(0, 3) != 0);
      w = ($urandom_range(0, 9) == 0) ? conv3_pkg::COL_W'($urandom_range(13, 40))
                                      : conv3_pkg::COL_W'($urandom_range(0, 12));
      h = ($urandom_range(0, 9) == 0) ? conv3_pkg::HGT_W'($urandom_range(9, 20))
                                      : conv3_pkg::HGT_W'($urandom_range(0, 8));
      apply_setup(pick_coef_row(), pick_coef_row(), pick_coef_row(), pick_divisor(), w, h);
      // Geometry may change mid-frame only where the line stores already hold pixels.
      restart = !at_frame_start() && !stores_known(line_len());
      stream_pixels($urandom_range(20, 120), restart);
    end
    gaps_on = 1'b1;
  endtask

  // Out-of-range width and height clamp to the largest sizes, so a short first row
  // gives no result.
  task automatic test_oversize_geometry();
    finish_phase();
    apply_setup(pick_coef_row(), pick_coef_row(), pick_coef_row(), pick_divisor(),
                12'hFFF, 13'h1FFF);
    for (int k = 0; k < OVERSIZE_PIXELS; k++) send_pixel(pick_pixel(), k == 0);
  endtask

  initial begin
    reset_filter_model();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_identity_small_frames();
    test_saturation_limits();
    test_random_frames();
    test_oversize_geometry();
    finish_phase();
    $display("Run covered %0d pixels under %0d register settings, clamped sizes included.",
             pixels_sent, setups_done);
    $display("%0d filtered results checked: %0d saturated, %0d closing a frame.",
             results_checked, saturated_seen, frame_ends_seen);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    int stall;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      stall = gaps_on ? $urandom_range(0, 5) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    filter_result_t exp_res;
    if (rst_n && out_valid && out_ready) begin
      if (filter_results_due.size() == 0) begin
        $error("result with no pixel to account for it: filtered %0d", out_filtered);
        error_count++;
      end else begin
        exp_res = filter_results_due.pop_front();
        results_checked++;
        if (exp_res.saturated) saturated_seen++;
        if (exp_res.frame_last) frame_ends_seen++;
        if (out_filtered !== exp_res.filtered) begin
          $error("filtered: expected %0d, got %0d", exp_res.filtered, out_filtered);
          error_count++;
        end
        if (out_saturated !== exp_res.saturated) begin
          $error("saturated: expected %0b, got %0b", exp_res.saturated, out_saturated);
          error_count++;
        end
        if (out_frame_last !== exp_res.frame_last) begin
          $error("frame_last: expected %0b, got %0b", exp_res.frame_last, out_frame_last);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $error("no transaction for %0d cycles, %0d results still due",
             idle_cycles, filter_results_due.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// ----- files.f -----
rtl/conv3_pkg.sv
rtl/conv3_ram.sv
rtl/conv3_mac.sv
rtl/conv3_div.sv
rtl/conv3x3_integer_kernel.sv
tb/tb.sv
